// ----- design/tsrs_pkg.sv -----
// Shared types and codes for the timestamp-sorted record table.
// No dependencies.
package tsrs_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int STAMP_W = 64;
    localparam int ID_W = 16;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CARRIED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0] record_id;
    } cell_ctl_t;

endpackage

// ----- design/timestamp_sorted_range_select.sv -----
// Channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | kind, stamp, record_id, range_start, range_end
// out     | out | out_valid/out_ready | status, out_stamp, out_record_id, last
//
// Insert and clear: accept, then execute into the output register.
// Query: accept, execute, scan the table, then flush; no scan for reversed bounds or an empty table;
// the chain rotates one record per cycle past slot 0, the only slot compared to the range.
// A stalled output freezes the rotation; the input side takes one item while the
// previous result waits. Reset empties the table (fill count only).
// Top level: sorted record table with range query. Depends on tsrs_pkg, tsrs_cell.
module timestamp_sorted_range_select
#(
    parameter int TABLE_DEPTH = tsrs_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tsrs_pkg::KIND_W-1:0]    kind,
    input  logic [tsrs_pkg::STAMP_W-1:0]   stamp,
    input  logic [tsrs_pkg::ID_W-1:0]      record_id,
    input  logic [tsrs_pkg::STAMP_W-1:0]   range_start,
    input  logic [tsrs_pkg::STAMP_W-1:0]   range_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tsrs_pkg::STATUS_W-1:0]  status,
    output logic [tsrs_pkg::STAMP_W-1:0]   out_stamp,
    output logic [tsrs_pkg::ID_W-1:0]      out_record_id,
    output logic                           last
);

    localparam int FW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] cnt_reg, cnt_next;

    logic [tsrs_pkg::KIND_W-1:0]  kind_reg;
    logic [tsrs_pkg::STAMP_W-1:0] stamp_reg;
    logic [tsrs_pkg::ID_W-1:0]    id_reg;
    logic [tsrs_pkg::STAMP_W-1:0] lo_reg;
    logic [tsrs_pkg::STAMP_W-1:0] hi_reg;

    logic                         pend_valid_reg, pend_valid_next;
    logic [tsrs_pkg::STAMP_W-1:0] pend_stamp_reg, pend_stamp_next;
    logic [tsrs_pkg::ID_W-1:0]    pend_id_reg, pend_id_next;

    logic                          out_valid_reg;
    logic [tsrs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tsrs_pkg::STAMP_W-1:0]  out_stamp_reg, out_stamp_next;
    logic [tsrs_pkg::ID_W-1:0]     out_id_reg, out_id_next;
    logic                          last_reg, last_next;
    logic                          out_load;
    logic                          out_free;

    tsrs_pkg::cell_ctl_t ctl;

    logic [tsrs_pkg::STAMP_W-1:0] cell_stamp [TABLE_DEPTH];
    logic [tsrs_pkg::ID_W-1:0]    cell_id [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       cell_gt;
    logic [TABLE_DEPTH-1:0]       cell_occ;

    logic head_match;
    logic full;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign full = (fill_reg == FW'(TABLE_DEPTH));
    assign head_match = (cell_stamp[0] >= lo_reg) && (cell_stamp[0] <= hi_reg);

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign out_stamp = out_stamp_reg;
    assign out_record_id = out_id_reg;
    assign last = last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic                         l_occ;
            logic                         l_gt;
            logic [tsrs_pkg::STAMP_W-1:0] l_stamp;
            logic [tsrs_pkg::ID_W-1:0]    l_id;
            logic [tsrs_pkg::STAMP_W-1:0] r_stamp;
            logic [tsrs_pkg::ID_W-1:0]    r_id;

            assign cell_occ[gi] = (fill_reg > FW'(gi));

            if (gi == 0)
            begin : g_head
                assign l_occ = 1'b1;
                assign l_gt = 1'b0;
                assign l_stamp = '0;
                assign l_id = '0;
            end
            else
            begin : g_body
                assign l_occ = cell_occ[gi-1];
                assign l_gt = cell_gt[gi-1];
                assign l_stamp = cell_stamp[gi-1];
                assign l_id = cell_id[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign r_stamp = cell_stamp[0];
                assign r_id = cell_id[0];
            end
            else
            begin : g_mid
                assign r_stamp = (fill_reg == FW'(gi + 1)) ? cell_stamp[0] : cell_stamp[gi+1];
                assign r_id = (fill_reg == FW'(gi + 1)) ? cell_id[0] : cell_id[gi+1];
            end

            tsrs_cell u_cell
            (
                .clk         (clk),
                .ctl         (ctl),
                .occ         (cell_occ[gi]),
                .left_occ    (l_occ),
                .left_gt     (l_gt),
                .left_stamp  (l_stamp),
                .left_id     (l_id),
                .right_stamp (r_stamp),
                .right_id    (r_id),
                .stamp       (cell_stamp[gi]),
                .record_id   (cell_id[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_stamp_next = pend_stamp_reg;
        pend_id_next = pend_id_reg;
        out_load = 1'b0;
        status_next = status_reg;
        out_stamp_next = out_stamp_reg;
        out_id_next = out_id_reg;
        last_next = last_reg;
        ctl.op = tsrs_pkg::CELL_HOLD;
        ctl.stamp = stamp_reg;
        ctl.record_id = id_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (kind_reg)
                    tsrs_pkg::KIND_INSERT:
                    begin
                        if (out_free)
                        begin
                            out_load = 1'b1;
                            out_stamp_next = '0;
                            out_id_next = '0;
                            last_next = 1'b1;
                            state_next = S_IDLE;
                            if (full)
                            begin
                                status_next = tsrs_pkg::ST_DROPPED;
                            end
                            else
                            begin
                                status_next = tsrs_pkg::ST_INSERTED;
                                ctl.op = tsrs_pkg::CELL_INSERT;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                    end
                    tsrs_pkg::KIND_QUERY:
                    begin
                        pend_valid_next = 1'b0;
                        cnt_next = '0;
                        if ((lo_reg > hi_reg) || (fill_reg == '0))
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    tsrs_pkg::KIND_CLEAR:
                    begin
                        if (out_free)
                        begin
                            out_load = 1'b1;
                            status_next = tsrs_pkg::ST_CLEARED;
                            out_stamp_next = '0;
                            out_id_next = '0;
                            last_next = 1'b1;
                            fill_next = '0;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    ctl.op = tsrs_pkg::CELL_ROTATE;
                    cnt_next = cnt_reg + FW'(1);
                    if (head_match)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            status_next = tsrs_pkg::ST_CARRIED;
                            out_stamp_next = pend_stamp_reg;
                            out_id_next = pend_id_reg;
                            last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_stamp_next = cell_stamp[0];
                        pend_id_next = cell_id[0];
                    end
                    if (cnt_reg == fill_reg - FW'(1))
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    last_next = 1'b1;
                    state_next = S_IDLE;
                    if (pend_valid_reg)
                    begin
                        status_next = tsrs_pkg::ST_CARRIED;
                        out_stamp_next = pend_stamp_reg;
                        out_id_next = pend_id_reg;
                    end
                    else
                    begin
                        status_next = tsrs_pkg::ST_NOMATCH;
                        out_stamp_next = '0;
                        out_id_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            cnt_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            cnt_reg <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            stamp_reg <= stamp;
            id_reg <= record_id;
            lo_reg <= range_start;
            hi_reg <= range_end;
        end
        pend_stamp_reg <= pend_stamp_next;
        pend_id_reg <= pend_id_next;
        status_reg <= status_next;
        out_stamp_reg <= out_stamp_next;
        out_id_reg <= out_id_next;
        last_reg <= last_next;
    end

endmodule

// ----- design/tsrs_cell.sv -----
// One slot of the sorted chain: holds a record, shifts right on insert,
// shifts left (toward slot 0) on a scan rotation. Depends on tsrs_pkg.
module tsrs_cell
(
    input  logic                        clk,
    input  tsrs_pkg::cell_ctl_t         ctl,
    input  logic                        occ,
    input  logic                        left_occ,
    input  logic                        left_gt,
    input  logic [tsrs_pkg::STAMP_W-1:0] left_stamp,
    input  logic [tsrs_pkg::ID_W-1:0]    left_id,
    input  logic [tsrs_pkg::STAMP_W-1:0] right_stamp,
    input  logic [tsrs_pkg::ID_W-1:0]    right_id,
    output logic [tsrs_pkg::STAMP_W-1:0] stamp,
    output logic [tsrs_pkg::ID_W-1:0]    record_id,
    output logic                        gt
);

    logic [tsrs_pkg::STAMP_W-1:0] stamp_reg;
    logic [tsrs_pkg::STAMP_W-1:0] stamp_next;
    logic [tsrs_pkg::ID_W-1:0]    id_reg;
    logic [tsrs_pkg::ID_W-1:0]    id_next;

    assign gt = occ && (stamp_reg > ctl.stamp);
    assign stamp = stamp_reg;
    assign record_id = id_reg;

    always_comb
    begin
        stamp_next = stamp_reg;
        id_next = id_reg;
        case (ctl.op)
            tsrs_pkg::CELL_INSERT:
            begin
                if (left_gt)
                begin
                    stamp_next = left_stamp;
                    id_next = left_id;
                end
                else if (gt || (!occ && left_occ))
                begin
                    stamp_next = ctl.stamp;
                    id_next = ctl.record_id;
                end
            end
            tsrs_pkg::CELL_ROTATE:
            begin
                if (occ)
                begin
                    stamp_next = right_stamp;
                    id_next = right_id;
                end
            end
            default:
            begin
                stamp_next = stamp_reg;
                id_next = id_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        id_reg <= id_next;
    end

endmodule

// ----- design/tsrs_checker.sv -----
// Port-level checks for timestamp_sorted_range_select, attached by bind.
// Depends on tsrs_pkg.
module tsrs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tsrs_pkg::STATUS_W-1:0] status,
    input logic [tsrs_pkg::STAMP_W-1:0]  out_stamp,
    input logic [tsrs_pkg::ID_W-1:0]     out_record_id,
    input logic                          last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_stamp)
            && $stable(out_record_id) && $stable(last))
        else $error("output item changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= tsrs_pkg::ST_CLEARED)
        else $error("status code out of range");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != tsrs_pkg::ST_CARRIED |-> out_stamp == '0
            && out_record_id == '0 && last)
        else $error("single result must be last with zero payload");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in execution");

endmodule

bind timestamp_sorted_range_select tsrs_checker u_tsrs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_stamp     (out_stamp),
    .out_record_id (out_record_id),
    .last          (last)
);
